// File: design/box_trigger_entry_detector_top_macros.svh
// assertion macros for the box trigger entry detector
// used by box_trigger_entry_detector_top; relies on ports clock and reset
`ifndef BOX_TRIGGER_ENTRY_DETECTOR_TOP_MACROS_SVH
`define BOX_TRIGGER_ENTRY_DETECTOR_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define BTD_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("btd invariant violated");

// consequence holds in the same cycle
`define BTD_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("btd implication violated");

// consequence holds in the next cycle
`define BTD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("btd sequence violated");

`endif

// File: design/btd_pkg.sv
// shared constants, codes and types of the box trigger entry detector
// no dependencies
package btd_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int COORD_BITS  = 24;
   localparam int FIELD_W     = 24;
   localparam int ID_W        = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int BND_W       = 6 * COORD_BITS;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_CREATE = 2'd1,
      KIND_CHECK  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_FIRED   = 2'd2,
      STAT_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // low COORD_BITS bits of an input field, zero extended when wider
   function automatic coord_type to_coord(input logic [FIELD_W-1:0] raw);
      logic [COORD_BITS+FIELD_W-1:0] wide;
      wide = {{COORD_BITS{1'b0}}, raw};
      return wide[COORD_BITS-1:0];
   endfunction

endpackage

// File: design/box_trigger_entry_detector_top.sv
// box trigger entry detector: box table in memory, scan sequencer, result register
// depends on btd_pkg and box_trigger_entry_detector_top_macros.svh
//
//   channel | ports           | direction | moves
//   req     | req_valid/stall | in        | clear, create or check item
//   rsp     | rsp_valid/stall | out       | created, full, fired, done or ignored result
//
// clear, create, dead check and unknown items pass through the EXEC state to the result register.
// a live check reads one table entry per cycle from the bound and id memories,
// a rate set by the single read port, until all entry_count entries are read.
// the scan halts on a fire while the previous result is stalled; the next item is taken
// while the last result still waits. reset (synchronous) empties the table, next id to 1.
`include "box_trigger_entry_detector_top_macros.svh"

module box_trigger_entry_detector_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic signed [btd_pkg::FIELD_W-1:0] req_lo_x,
   input  logic signed [btd_pkg::FIELD_W-1:0] req_lo_y,
   input  logic signed [btd_pkg::FIELD_W-1:0] req_lo_z,
   input  logic signed [btd_pkg::FIELD_W-1:0] req_hi_x,
   input  logic signed [btd_pkg::FIELD_W-1:0] req_hi_y,
   input  logic signed [btd_pkg::FIELD_W-1:0] req_hi_z,
   input  logic                               req_trigger_type,
   input  logic                               req_entity_dead,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [15:0]                        rsp_trigger_id,
   output logic [3:0]                         rsp_slot,
   output logic [4:0]                         rsp_fire_count,
   output logic                               rsp_last
);
   import btd_pkg::*;

   // control state
   state_type              state_ff, state_in;
   logic [MAX_ENTRIES-1:0] type_flags_ff, type_flags_in;
   logic [MAX_ENTRIES-1:0] en_flags_ff, en_flags_in;
   logic [MAX_ENTRIES-1:0] occ_flags_ff, occ_flags_in;
   logic [MAX_ENTRIES-1:0] fired_flags_ff, fired_flags_in;
   logic [CNT_W-1:0]       entry_cnt_ff, entry_cnt_in;
   logic [ID_W-1:0]        next_id_ff, next_id_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]       ev_idx_ff, ev_idx_in;
   logic [CNT_W-1:0]       fire_cnt_ff, fire_cnt_in;
   logic                   rsp_vld_ff, rsp_vld_in;

   // result payload
   status_type             rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [3:0]             rsp_slot_ff, rsp_slot_in;
   logic [4:0]             rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_last_ff, rsp_last_in;

   // captured item
   logic [1:0]             kind_ff;
   coord_type              lo_ff [3];
   coord_type              hi_ff [3];
   logic                   trig_type_ff;
   logic                   dead_ff;

   // table memories
   logic [BND_W-1:0]       bnd_mem [MAX_ENTRIES];
   logic [ID_W-1:0]        id_mem  [MAX_ENTRIES];
   logic [BND_W-1:0]       bnd_rd_ff;
   logic [ID_W-1:0]        id_rd_ff;
   logic                   mem_wr;
   logic                   mem_rd;
   logic [IDX_W-1:0]       wr_addr;
   logic [IDX_W-1:0]       rd_addr;

   // scan evaluation
   logic                   req_acc;
   logic                   out_free;
   logic                   ev_inside;
   logic                   ev_fire;
   logic                   ev_adv;
   logic                   rd_more;

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign wr_addr  = entry_cnt_ff[IDX_W-1:0];
   assign rd_addr  = rd_idx_ff[IDX_W-1:0];
   assign rd_more  = rd_idx_ff < entry_cnt_ff;

   // item capture on transfer
   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff      <= req_kind;
         lo_ff[0]     <= to_coord(req_lo_x);
         lo_ff[1]     <= to_coord(req_lo_y);
         lo_ff[2]     <= to_coord(req_lo_z);
         hi_ff[0]     <= to_coord(req_hi_x);
         hi_ff[1]     <= to_coord(req_hi_y);
         hi_ff[2]     <= to_coord(req_hi_z);
         trig_type_ff <= req_trigger_type;
         dead_ff      <= req_entity_dead;
      end
   end

   // bound and id memories, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         bnd_mem[wr_addr] <= {hi_ff[2], hi_ff[1], hi_ff[0], lo_ff[2], lo_ff[1], lo_ff[0]};
         id_mem[wr_addr]  <= next_id_ff;
      end
      if (mem_rd) begin
         bnd_rd_ff <= bnd_mem[rd_addr];
         id_rd_ff  <= id_mem[rd_addr];
      end
   end

   // inclusive point-in-box test on the entry just read
   always_comb begin
      coord_type lo_c;
      coord_type hi_c;
      ev_inside = 1'b1;
      for (int a = 0; a < 3; a++) begin
         lo_c = bnd_rd_ff[a*COORD_BITS +: COORD_BITS];
         hi_c = bnd_rd_ff[(a+3)*COORD_BITS +: COORD_BITS];
         if (lo_ff[a] < lo_c || lo_ff[a] > hi_c)
            ev_inside = 1'b0;
      end
   end

   // entry fires on entering, unless a once box already fired
   assign ev_fire = ev_vld_ff && en_flags_ff[ev_idx_ff] && ev_inside &&
                    !occ_flags_ff[ev_idx_ff] &&
                    !(type_flags_ff[ev_idx_ff] && fired_flags_ff[ev_idx_ff]);
   assign ev_adv  = !ev_vld_ff || !ev_fire || out_free;

   // next state, table updates and result loading
   always_comb begin
      state_in       = state_ff;
      type_flags_in  = type_flags_ff;
      en_flags_in    = en_flags_ff;
      occ_flags_in   = occ_flags_ff;
      fired_flags_in = fired_flags_ff;
      entry_cnt_in   = entry_cnt_ff;
      next_id_in     = next_id_ff;
      rd_idx_in      = rd_idx_ff;
      ev_vld_in      = ev_vld_ff;
      ev_idx_in      = ev_idx_ff;
      fire_cnt_in    = fire_cnt_ff;
      rsp_vld_in     = rsp_vld_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_last_in    = rsp_last_ff;
      mem_wr         = 1'b0;
      mem_rd         = 1'b0;
      req_stall      = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = ST_EXEC;
         end

         ST_EXEC: begin
            case (kind_ff)
               KIND_CLEAR: begin
                  if (out_free) begin
                     type_flags_in  = '0;
                     en_flags_in    = '0;
                     occ_flags_in   = '0;
                     fired_flags_in = '0;
                     entry_cnt_in   = '0;
                     next_id_in     = ID_W'(1);
                     rsp_vld_in     = 1'b1;
                     rsp_status_in  = STAT_OK;
                     rsp_id_in      = '0;
                     rsp_slot_in    = '0;
                     rsp_cnt_in     = '0;
                     rsp_last_in    = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end

               KIND_CREATE: begin
                  if (out_free) begin
                     rsp_vld_in  = 1'b1;
                     rsp_cnt_in  = '0;
                     rsp_last_in = 1'b1;
                     state_in    = ST_IDLE;
                     if (entry_cnt_ff >= CNT_W'(MAX_ENTRIES)) begin
                        rsp_status_in = STAT_FULL;
                        rsp_id_in     = '0;
                        rsp_slot_in   = '0;
                     end else begin
                        mem_wr                  = 1'b1;
                        type_flags_in[wr_addr]  = trig_type_ff;
                        en_flags_in[wr_addr]    = 1'b1;
                        occ_flags_in[wr_addr]   = 1'b0;
                        fired_flags_in[wr_addr] = 1'b0;
                        entry_cnt_in            = entry_cnt_ff + CNT_W'(1);
                        next_id_in              = next_id_ff + ID_W'(1);
                        rsp_status_in           = STAT_OK;
                        rsp_id_in               = next_id_ff;
                        rsp_slot_in             = 4'(wr_addr);
                     end
                  end
               end

               KIND_CHECK: begin
                  if (dead_ff) begin
                     if (out_free) begin
                        rsp_vld_in    = 1'b1;
                        rsp_status_in = STAT_OK;
                        rsp_id_in     = '0;
                        rsp_slot_in   = '0;
                        rsp_cnt_in    = '0;
                        rsp_last_in   = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end else begin
                     rd_idx_in   = '0;
                     ev_vld_in   = 1'b0;
                     fire_cnt_in = '0;
                     state_in    = ST_SCAN;
                  end
               end

               default: begin
                  if (out_free) begin
                     rsp_vld_in    = 1'b1;
                     rsp_status_in = STAT_IGNORED;
                     rsp_id_in     = '0;
                     rsp_slot_in   = '0;
                     rsp_cnt_in    = '0;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
            endcase
         end

         ST_SCAN: begin
            // flag update of the entry under evaluation
            if (ev_vld_ff && ev_adv && en_flags_ff[ev_idx_ff]) begin
               if (ev_inside && !occ_flags_ff[ev_idx_ff]) begin
                  occ_flags_in[ev_idx_ff] = 1'b1;
                  if (ev_fire) begin
                     fired_flags_in[ev_idx_ff] = 1'b1;
                     if (type_flags_ff[ev_idx_ff])
                        en_flags_in[ev_idx_ff] = 1'b0;
                     fire_cnt_in   = fire_cnt_ff + CNT_W'(1);
                     rsp_vld_in    = 1'b1;
                     rsp_status_in = STAT_FIRED;
                     rsp_id_in     = id_rd_ff;
                     rsp_slot_in   = 4'(ev_idx_ff);
                     rsp_cnt_in    = '0;
                     rsp_last_in   = 1'b0;
                  end
               end else if (!ev_inside && occ_flags_ff[ev_idx_ff]) begin
                  occ_flags_in[ev_idx_ff] = 1'b0;
               end
            end

            // read of the next entry
            if (ev_adv) begin
               if (rd_more) begin
                  mem_rd    = 1'b1;
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  ev_vld_in = 1'b1;
                  ev_idx_in = rd_addr;
               end else begin
                  ev_vld_in = 1'b0;
               end
            end

            // done result once the table is drained
            if (!ev_vld_ff && !rd_more && out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_id_in     = '0;
               rsp_slot_in   = '0;
               rsp_cnt_in    = 5'(fire_cnt_ff);
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         type_flags_ff  <= '0;
         en_flags_ff    <= '0;
         occ_flags_ff   <= '0;
         fired_flags_ff <= '0;
         entry_cnt_ff   <= '0;
         next_id_ff     <= ID_W'(1);
         rd_idx_ff      <= '0;
         ev_vld_ff      <= 1'b0;
         fire_cnt_ff    <= '0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         type_flags_ff  <= type_flags_in;
         en_flags_ff    <= en_flags_in;
         occ_flags_ff   <= occ_flags_in;
         fired_flags_ff <= fired_flags_in;
         entry_cnt_ff   <= entry_cnt_in;
         next_id_ff     <= next_id_in;
         rd_idx_ff      <= rd_idx_in;
         ev_vld_ff      <= ev_vld_in;
         fire_cnt_ff    <= fire_cnt_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_idx_ff     <= ev_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // result port
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_trigger_id = rsp_id_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_fire_count = rsp_cnt_ff;
   assign rsp_last       = rsp_last_ff;

   // checks
   `BTD_ASSERT_ALWAYS(a_cnt_range, entry_cnt_ff <= CNT_W'(MAX_ENTRIES))
   `BTD_ASSERT_ALWAYS(a_once_off, (type_flags_ff & fired_flags_ff & en_flags_ff) == '0)
   `BTD_ASSERT_IMPLY(a_ev_in_scan, ev_vld_ff, state_ff == ST_SCAN)
   `BTD_ASSERT_NEXT(a_acc_exec, req_valid && !req_stall, state_ff == ST_EXEC)

endmodule

// File: sim/btd_trigger_checker.sv
// checker for the box trigger entry detector: watches both channels, predicts, compares
// depends on btd_pkg; instantiated beside the block by tb_box_trigger_entry_detector_top
module btd_trigger_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [btd_pkg::FIELD_W-1:0] req_lo_x,
   input  logic [btd_pkg::FIELD_W-1:0] req_lo_y,
   input  logic [btd_pkg::FIELD_W-1:0] req_lo_z,
   input  logic [btd_pkg::FIELD_W-1:0] req_hi_x,
   input  logic [btd_pkg::FIELD_W-1:0] req_hi_y,
   input  logic [btd_pkg::FIELD_W-1:0] req_hi_z,
   input  logic                        req_trigger_type,
   input  logic                        req_entity_dead,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [1:0]                  rsp_status,
   input  logic [15:0]                 rsp_trigger_id,
   input  logic [3:0]                  rsp_slot,
   input  logic [4:0]                  rsp_fire_count,
   input  logic                        rsp_last,
   output int                          fail_count,
   output int                          pending,
   output int                          results_seen,
   output int                          fires_seen,
   output int                          full_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import btd_pkg::*;

   typedef struct {
      status_type  status;
      logic [15:0] trigger_id;
      logic [3:0]  slot;
      logic [4:0]  fire_count;
      logic        last;
   } outcome_type;

   // shadow copy of the box table
   coord_type             box_lo [MAX_ENTRIES][3];
   coord_type             box_hi [MAX_ENTRIES][3];
   logic [15:0]           box_tag [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] once_mask;
   logic [MAX_ENTRIES-1:0] armed_mask;
   logic [MAX_ENTRIES-1:0] inside_mask;
   logic [MAX_ENTRIES-1:0] fired_mask;
   int                    boxes_used;
   logic [15:0]           next_tag;

   outcome_type outcome_q[$];
   int          err_count;
   int          rsp_count;
   int          fire_total;
   int          full_total;

   // clear of the shadow table, also the reset state
   task automatic clear_table();
      once_mask   = '0;
      armed_mask  = '0;
      inside_mask = '0;
      fired_mask  = '0;
      boxes_used  = 0;
      next_tag    = 16'd1;
   endtask

   task automatic queue_outcome(input status_type st, input logic [15:0] tag,
                                input logic [3:0] slot, input logic [4:0] count,
                                input logic last);
      outcome_type o;
      o.status     = st;
      o.trigger_id = tag;
      o.slot       = slot;
      o.fire_count = count;
      o.last       = last;
      outcome_q.push_back(o);
   endtask

   // inclusive on all six faces, signed compare
   function automatic logic box_contains(input int s, input coord_type pt[3]);
      int a;
      for (a = 0; a < 3; a++) begin
         if (pt[a] < box_lo[s][a] || pt[a] > box_hi[s][a])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // expected results of one transfer on the request side
   task automatic run_trigger_table();
      coord_type pt[3];
      int        s;
      int        fires;
      logic      hit;
      case (req_kind)
         KIND_CLEAR: begin
            clear_table();
            queue_outcome(STAT_OK, 16'd0, 4'd0, 5'd0, 1'b1);
         end
         KIND_CREATE: begin
            if (boxes_used >= MAX_ENTRIES) begin
               queue_outcome(STAT_FULL, 16'd0, 4'd0, 5'd0, 1'b1);
            end else begin
               s = boxes_used;
               box_lo[s][0] = req_lo_x;
               box_lo[s][1] = req_lo_y;
               box_lo[s][2] = req_lo_z;
               box_hi[s][0] = req_hi_x;
               box_hi[s][1] = req_hi_y;
               box_hi[s][2] = req_hi_z;
               box_tag[s]   = next_tag;
               next_tag     = next_tag + 16'd1;
               once_mask[s]   = req_trigger_type;
               armed_mask[s]  = 1'b1;
               inside_mask[s] = 1'b0;
               fired_mask[s]  = 1'b0;
               boxes_used     = s + 1;
               queue_outcome(STAT_OK, box_tag[s], s[3:0], 5'd0, 1'b1);
            end
         end
         KIND_CHECK: begin
            if (req_entity_dead) begin
               queue_outcome(STAT_OK, 16'd0, 4'd0, 5'd0, 1'b1);
            end else begin
               pt[0] = req_lo_x;
               pt[1] = req_lo_y;
               pt[2] = req_lo_z;
               fires = 0;
               // ascending slot scan, entry fires, exit clears occupancy
               for (s = 0; s < boxes_used; s++) begin
                  if (armed_mask[s]) begin
                     hit = box_contains(s, pt);
                     if (hit && !inside_mask[s]) begin
                        inside_mask[s] = 1'b1;
                        if (!(once_mask[s] && fired_mask[s])) begin
                           fired_mask[s] = 1'b1;
                           if (once_mask[s])
                              armed_mask[s] = 1'b0;
                           queue_outcome(STAT_FIRED, box_tag[s], s[3:0], 5'd0, 1'b0);
                           fires++;
                        end
                     end else if (!hit && inside_mask[s]) begin
                        inside_mask[s] = 1'b0;
                     end
                  end
               end
               queue_outcome(STAT_OK, 16'd0, 4'd0, fires[4:0], 1'b1);
            end
         end
         default: begin
            queue_outcome(STAT_IGNORED, 16'd0, 4'd0, 5'd0, 1'b1);
         end
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      err_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // compare one result transfer with the oldest expectation
   task automatic compare_result();
      outcome_type o;
      rsp_count++;
      if (outcome_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result status=%0d id=%0d slot=%0d",
                                   rsp_status, rsp_trigger_id, rsp_slot));
      end else begin
         o = outcome_q.pop_front();
         if (rsp_status !== o.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp_status, o.status));
         if (rsp_trigger_id !== o.trigger_id)
            report_mismatch($sformatf("trigger_id got %0d want %0d",
                                      rsp_trigger_id, o.trigger_id));
         if (rsp_slot !== o.slot)
            report_mismatch($sformatf("slot got %0d want %0d", rsp_slot, o.slot));
         if (rsp_fire_count !== o.fire_count)
            report_mismatch($sformatf("fire_count got %0d want %0d",
                                      rsp_fire_count, o.fire_count));
         if (rsp_last !== o.last)
            report_mismatch($sformatf("last got %0d want %0d", rsp_last, o.last));
         if (o.status == STAT_FIRED)
            fire_total++;
         if (o.status == STAT_FULL)
            full_total++;
      end
   endtask

   initial begin
      err_count  = 0;
      rsp_count  = 0;
      fire_total = 0;
      full_total = 0;
      clear_table();
   end

   // watch both channels at every edge
   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         outcome_q.delete();
      end else begin
         if (req_valid && !req_stall)
            run_trigger_table();
         if (rsp_valid && !rsp_stall)
            compare_result();
      end
      fail_count   <= err_count;
      pending      <= outcome_q.size();
      results_seen <= rsp_count;
      fires_seen   <= fire_total;
      full_seen    <= full_total;
   end

endmodule

// File: sim/tb_box_trigger_entry_detector_top.sv
// testbench top for box_trigger_entry_detector_top: clock, reset, stimulus and verdict
// depends on btd_pkg, the block itself and btd_trigger_checker
module tb_box_trigger_entry_detector_top;
   timeunit 1ns;
   timeprecision 1ps;
   import btd_pkg::*;

   localparam logic [1:0] KIND_UNKNOWN  = 2'd3;
   localparam int         RANDOM_ITEMS  = 150;
   localparam int         DRAIN_CYCLES  = 60;
   localparam int         CYCLE_LIMIT   = 600000;
   localparam coord_type  COORD_MIN     = 24'sh800000;
   localparam coord_type  COORD_MAX     = 24'sh7FFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_CLEAR;
   coord_type   req_lo_x = '0;
   coord_type   req_lo_y = '0;
   coord_type   req_lo_z = '0;
   coord_type   req_hi_x = '0;
   coord_type   req_hi_y = '0;
   coord_type   req_hi_z = '0;
   logic        req_trigger_type = 1'b0;
   logic        req_entity_dead = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_trigger_id;
   logic [3:0]  rsp_slot;
   logic [4:0]  rsp_fire_count;
   logic        rsp_last;

   int fail_count;
   int pending;
   int results_seen;
   int fires_seen;
   int full_seen;
   int cycle_count = 0;
   int directed_sent = 0;
   int random_sent = 0;
   bit req_calm = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   box_trigger_entry_detector_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_lo_x         (req_lo_x),
      .req_lo_y         (req_lo_y),
      .req_lo_z         (req_lo_z),
      .req_hi_x         (req_hi_x),
      .req_hi_y         (req_hi_y),
      .req_hi_z         (req_hi_z),
      .req_trigger_type (req_trigger_type),
      .req_entity_dead  (req_entity_dead),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_trigger_id   (rsp_trigger_id),
      .rsp_slot         (rsp_slot),
      .rsp_fire_count   (rsp_fire_count),
      .rsp_last         (rsp_last)
   );

   btd_trigger_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_lo_x         (req_lo_x),
      .req_lo_y         (req_lo_y),
      .req_lo_z         (req_lo_z),
      .req_hi_x         (req_hi_x),
      .req_hi_y         (req_hi_y),
      .req_hi_z         (req_hi_z),
      .req_trigger_type (req_trigger_type),
      .req_entity_dead  (req_entity_dead),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_trigger_id   (rsp_trigger_id),
      .rsp_slot         (rsp_slot),
      .rsp_fire_count   (rsp_fire_count),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .pending          (pending),
      .results_seen     (results_seen),
      .fires_seen       (fires_seen),
      .full_seen        (full_seen)
   );

   // hard stop on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: after each transfer stall for a drawn number of cycles
   initial begin : rsp_side
      int hold;
      int xfers;
      bit calm;
      hold  = 0;
      xfers = 0;
      calm  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            xfers++;
            if (xfers % 32 == 0)
               calm = ($urandom_range(0, 3) == 0);
            hold = calm ? 0 : $urandom_range(0, 7);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   // one request transfer, called at a rising edge, returns at the transfer edge
   task automatic push_item(input logic [1:0] kind,
                            input coord_type lx, input coord_type ly, input coord_type lz,
                            input coord_type hx, input coord_type hy, input coord_type hz,
                            input logic tt, input logic dead);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind         <= kind;
      req_lo_x         <= lx;
      req_lo_y         <= ly;
      req_lo_z         <= lz;
      req_hi_x         <= hx;
      req_hi_y         <= hy;
      req_hi_z         <= hz;
      req_trigger_type <= tt;
      req_entity_dead  <= dead;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic coord_type wide_coord();
      logic [31:0] raw;
      raw = $urandom;
      return raw[COORD_BITS-1:0];
   endfunction

   // mostly near the origin so boxes and points meet, now and then anywhere
   function automatic coord_type near_coord(input int span);
      int v;
      case ($urandom_range(0, 31))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2, 3, 4: return wide_coord();
         default: begin
            v = int'($urandom_range(0, 2 * span)) - span;
            return v[COORD_BITS-1:0];
         end
      endcase
   endfunction

   task automatic random_create();
      coord_type lo[3];
      coord_type hi[3];
      int        a;
      int        v;
      for (a = 0; a < 3; a++) begin
         v     = int'($urandom_range(0, 28)) - 16;
         lo[a] = v[COORD_BITS-1:0];
         v     = v + int'($urandom_range(0, 8));
         hi[a] = v[COORD_BITS-1:0];
      end
      // inverted on one axis
      if ($urandom_range(0, 9) == 0) begin
         a     = $urandom_range(0, 2);
         hi[a] = lo[a] - coord_type'($urandom_range(1, 3));
      end
      // arbitrary bounds
      if ($urandom_range(0, 9) == 0) begin
         for (a = 0; a < 3; a++) begin
            lo[a] = wide_coord();
            hi[a] = wide_coord();
         end
      end
      push_item(KIND_CREATE, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic random_check();
      push_item(KIND_CHECK, near_coord(20), near_coord(20), near_coord(20),
                wide_coord(), wide_coord(), wide_coord(),
                1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
   endtask

   task automatic random_clear();
      push_item(KIND_CLEAR, wide_coord(), wide_coord(), wide_coord(),
                wide_coord(), wide_coord(), wide_coord(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // directed: extremes, faces, once and repeat boxes, dead entity, full table
   task automatic run_directed();
      int i;
      coord_type b;
      push_item(KIND_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
      push_item(KIND_CREATE, COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
      push_item(KIND_CREATE, COORD_MAX - 24'sd256, COORD_MAX - 24'sd256, COORD_MAX - 24'sd256,
                COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
      push_item(KIND_CREATE, 24'sd100, COORD_MIN, COORD_MIN,
                -24'sd100, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
      push_item(KIND_CREATE, -24'sd256, -24'sd256, -24'sd256,
                24'sd256, 24'sd256, 24'sd256, 1'b0, 1'b0);
      // corner of the space: full box and once box fire
      push_item(KIND_CHECK, COORD_MAX, COORD_MAX, COORD_MAX,
                COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
      // still inside, nothing fires
      push_item(KIND_CHECK, COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0, 1'b0, 1'b0);
      push_item(KIND_CHECK, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
      push_item(KIND_CHECK, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
      // just past a face, leaves the small box
      push_item(KIND_CHECK, 24'sd257, '0, '0, '0, '0, '0, 1'b0, 1'b0);
      // back on the faces, repeat box fires again
      push_item(KIND_CHECK, 24'sd256, -24'sd256, 24'sd256, '0, '0, '0, 1'b0, 1'b0);
      push_item(KIND_CHECK, COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0, 1'b0, 1'b0);
      push_item(KIND_UNKNOWN, COORD_MAX, COORD_MIN, COORD_MAX,
                COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1);
      // fill the remaining slots, then one more create is rejected
      for (i = 4; i < MAX_ENTRIES; i++) begin
         b = coord_type'(i * 4);
         push_item(KIND_CREATE, -b, -b, -b, b, b, b, i[0], 1'b0);
      end
      push_item(KIND_CREATE, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
      push_item(KIND_CHECK, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
      push_item(KIND_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
      directed_sent = 28;
   endtask

   // random: clear, a run of creates, then a run of checks, with some noise
   task automatic run_random();
      int n;
      int i;
      while (random_sent < RANDOM_ITEMS) begin
         req_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            random_clear();
            random_sent++;
         end
         if ($urandom_range(0, 7) == 0) begin
            push_item(KIND_UNKNOWN, wide_coord(), wide_coord(), wide_coord(),
                      wide_coord(), wide_coord(), wide_coord(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            random_sent++;
         end
         n = $urandom_range(1, 18);
         for (i = 0; i < n; i++) begin
            random_create();
            random_sent++;
         end
         n = $urandom_range(4, 14);
         for (i = 0; i < n; i++) begin
            random_check();
            random_sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      // let the count of the last transfer settle before waiting on it
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d directed and %0d random transfers, %0d results checked",
               directed_sent, random_sent, results_seen);
      $display("boxes fired %0d times, full table seen %0d times", fires_seen, full_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
